@@ rtl/core/pfde_pkg.sv @@
// Shared command codes and frame store constants for the page framebuffer draw engine.
package pfde_pkg;

   localparam int STORE_DEPTH = 1024;
   localparam int ADDR_W      = 10;
   localparam int IDX_W       = 14;

   typedef enum logic [2:0] {
      CMD_CLEAR   = 3'd0,
      CMD_SET     = 3'd1,
      CMD_GET     = 3'd2,
      CMD_LINE    = 3'd3,
      CMD_OUTLINE = 3'd4,
      CMD_FILL    = 3'd5,
      CMD_BYTE    = 3'd6,
      CMD_NONE    = 3'd7
   } command_type;

endpackage

@@ rtl/core/page_framebuffer_draw_engine.sv @@
// Page-organized monochrome frame store with a sequenced pixel/line/rectangle drawing engine.
// A line walks its pixels in turn; a clipped pixel is stepped over without a store write;
//    outline is four lines back to back; fill is one line per row.
// Throughput: one request at a time; the per-pixel read-modify-write on the single store
//    port sets the pace; clear sweeps the store at 1 byte/cycle.
// Reset (synchronous, active high) starts a clearing pass of the whole store;
//    req_stall stays high until it finishes.
module page_framebuffer_draw_engine #(
   parameter int WIDTH  = 128,
   parameter int HEIGHT = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  pfde_pkg::command_type    req_command,
   input  logic [7:0]               req_x_start,
   input  logic [7:0]               req_y_start,
   input  logic [7:0]               req_x_end,
   input  logic [7:0]               req_y_end,
   input  logic                     req_ink,
   input  logic [9:0]               req_byte_address,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_pixel_value,
   output logic [7:0]               rsp_byte_value
);
   import pfde_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_CLEAR, S_SETUP, S_PLOT, S_MODIFY, S_BYTE_RD, S_BYTE_CAP, S_RESP
   } state_type;

   state_type   state_ff;
   command_type cmd_ff;
   logic [7:0]  xa_ff, ya_ff, xb_ff, yb_ff;
   logic [7:0]  lox_ff, hix_ff, hiy_ff, row_ff;
   logic        ink_ff;
   logic [ADDR_W-1:0] baddr_ff, clr_addr_ff;
   logic        clear_resp_ff;
   logic [1:0]  seg_ff;

   // line walker
   logic        xmaj_ff, neg_ff;
   logic [7:0]  maj_ff, min_ff, maj_span_ff, min_span_ff, steps_ff;
   logic [8:0]  rem_ff;

   logic        pv_ff;
   logic [7:0]  bv_ff;

   // frame store
   logic [7:0]  store_ff [STORE_DEPTH];
   logic [7:0]  rdata_ff;
   logic        mem_we;
   logic [ADDR_W-1:0] mem_waddr, mem_raddr;
   logic [7:0]  mem_wdata;

   // current segment endpoints
   logic [7:0]  s_x0, s_y0, s_x1, s_y1;
   logic [7:0]  adx, ady;
   logic        setup_xmaj;

   // pixel address
   logic [7:0]  px, py;
   logic [IDX_W-1:0] pix_idx;
   logic        pix_ok;
   logic [7:0]  pix_mask;

   logic        adv_en;
   logic [8:0]  rem_sum;
   logic        rem_carry;

   assign req_stall       = (state_ff != S_IDLE);
   assign rsp_valid       = (state_ff == S_RESP);
   assign rsp_pixel_value = pv_ff;
   assign rsp_byte_value  = bv_ff;

   // Pick the segment that the walker draws next.
   always_comb begin
      s_x0 = xa_ff; s_y0 = ya_ff; s_x1 = xa_ff; s_y1 = ya_ff;
      case (cmd_ff)
         CMD_LINE: begin
            s_x1 = xb_ff; s_y1 = yb_ff;
         end
         CMD_OUTLINE: begin
            case (seg_ff)
               2'd0: begin
                  s_x0 = xa_ff; s_y0 = ya_ff; s_x1 = xa_ff; s_y1 = yb_ff;
               end
               2'd1: begin
                  s_x0 = xa_ff; s_y0 = ya_ff; s_x1 = xb_ff; s_y1 = ya_ff;
               end
               2'd2: begin
                  s_x0 = xa_ff; s_y0 = yb_ff; s_x1 = xb_ff; s_y1 = yb_ff;
               end
               default: begin
                  s_x0 = xb_ff; s_y0 = ya_ff; s_x1 = xb_ff; s_y1 = yb_ff;
               end
            endcase
         end
         CMD_FILL: begin
            s_x0 = lox_ff; s_y0 = row_ff; s_x1 = hix_ff; s_y1 = row_ff;
         end
         default: ;
      endcase
      adx = (s_x1 >= s_x0) ? s_x1 - s_x0 : s_x0 - s_x1;
      ady = (s_y1 >= s_y0) ? s_y1 - s_y0 : s_y0 - s_y1;
      setup_xmaj = (adx >= ady);
   end

   // Pixel address of the walker position.
   always_comb begin
      px = xmaj_ff ? maj_ff : min_ff;
      py = xmaj_ff ? min_ff : maj_ff;
      pix_idx = IDX_W'(py[7:3]) * IDX_W'(WIDTH) + IDX_W'(px);
      pix_ok  = ({1'b0, px} < 9'(WIDTH)) && ({1'b0, py} < 9'(HEIGHT))
                && (pix_idx < IDX_W'(STORE_DEPTH));
      pix_mask = 8'h01 << py[2:0];
   end

   // Shared accumulate-and-compare unit of the walker.
   assign rem_sum   = rem_ff + {1'b0, min_span_ff};
   assign rem_carry = (rem_sum >= {1'b0, maj_span_ff});

   assign adv_en = ((state_ff == S_PLOT) && !pix_ok && (cmd_ff != CMD_GET))
                || ((state_ff == S_MODIFY) && (cmd_ff != CMD_GET));

   // Store port control.
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = pix_idx[ADDR_W-1:0];
      mem_wdata = ink_ff ? (rdata_ff | pix_mask) : (rdata_ff & ~pix_mask);
      mem_raddr = (state_ff == S_BYTE_RD) ? baddr_ff : pix_idx[ADDR_W-1:0];
      if (state_ff == S_CLEAR) begin
         mem_we    = 1'b1;
         mem_waddr = clr_addr_ff;
         mem_wdata = 8'h00;
      end else if ((state_ff == S_MODIFY) && (cmd_ff != CMD_GET)) begin
         mem_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_ff[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= store_ff[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_addr_ff   <= '0;
         clear_resp_ff <= 1'b0;
         cmd_ff        <= CMD_NONE;
         seg_ff        <= '0;
         pv_ff         <= 1'b0;
         bv_ff         <= '0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  // latch the request
                  cmd_ff   <= req_command;
                  xa_ff    <= req_x_start;
                  ya_ff    <= req_y_start;
                  xb_ff    <= req_x_end;
                  yb_ff    <= req_y_end;
                  ink_ff   <= req_ink;
                  baddr_ff <= req_byte_address;
                  lox_ff   <= (req_x_start <= req_x_end) ? req_x_start : req_x_end;
                  hix_ff   <= (req_x_start <= req_x_end) ? req_x_end : req_x_start;
                  row_ff   <= (req_y_start <= req_y_end) ? req_y_start : req_y_end;
                  hiy_ff   <= (req_y_start <= req_y_end) ? req_y_end : req_y_start;
                  seg_ff   <= '0;
                  pv_ff    <= 1'b0;
                  bv_ff    <= '0;
                  case (req_command)
                     CMD_CLEAR: begin
                        clr_addr_ff   <= '0;
                        clear_resp_ff <= 1'b1;
                        state_ff      <= S_CLEAR;
                     end
                     CMD_BYTE: state_ff <= S_BYTE_RD;
                     CMD_NONE: state_ff <= S_RESP;
                     default:  state_ff <= S_SETUP;
                  endcase
               end
            end
            S_CLEAR: begin
               clr_addr_ff <= clr_addr_ff + 1'b1;
               if (clr_addr_ff == ADDR_W'(STORE_DEPTH - 1)) begin
                  state_ff <= clear_resp_ff ? S_RESP : S_IDLE;
               end
            end
            S_SETUP: begin
               // start at the end with the smaller major coordinate
               xmaj_ff <= setup_xmaj;
               rem_ff  <= '0;
               if (setup_xmaj) begin
                  maj_span_ff <= adx;
                  min_span_ff <= ady;
                  steps_ff    <= adx;
                  if (s_x0 <= s_x1) begin
                     maj_ff <= s_x0; min_ff <= s_y0; neg_ff <= (s_y1 < s_y0);
                  end else begin
                     maj_ff <= s_x1; min_ff <= s_y1; neg_ff <= (s_y0 < s_y1);
                  end
               end else begin
                  maj_span_ff <= ady;
                  min_span_ff <= adx;
                  steps_ff    <= ady;
                  if (s_y0 <= s_y1) begin
                     maj_ff <= s_y0; min_ff <= s_x0; neg_ff <= (s_x1 < s_x0);
                  end else begin
                     maj_ff <= s_y1; min_ff <= s_x1; neg_ff <= (s_x0 < s_x1);
                  end
               end
               state_ff <= S_PLOT;
            end
            S_PLOT: begin
               if (pix_ok) begin
                  state_ff <= S_MODIFY;
               end else if (cmd_ff == CMD_GET) begin
                  state_ff <= S_RESP;
               end
            end
            S_MODIFY: begin
               if (cmd_ff == CMD_GET) begin
                  pv_ff    <= rdata_ff[py[2:0]];
                  state_ff <= S_RESP;
               end
            end
            S_BYTE_RD:  state_ff <= S_BYTE_CAP;
            S_BYTE_CAP: begin
               bv_ff    <= rdata_ff;
               state_ff <= S_RESP;
            end
            S_RESP: begin
               if (!rsp_stall) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase

         // Advance the walker after a drawn or clipped pixel.
         if (adv_en) begin
            if (steps_ff == 8'd0) begin
               if ((cmd_ff == CMD_OUTLINE) && (seg_ff != 2'd3)) begin
                  seg_ff   <= seg_ff + 1'b1;
                  state_ff <= S_SETUP;
               end else if ((cmd_ff == CMD_FILL) && (row_ff != hiy_ff)) begin
                  row_ff   <= row_ff + 1'b1;
                  state_ff <= S_SETUP;
               end else begin
                  state_ff <= S_RESP;
               end
            end else begin
               steps_ff <= steps_ff - 1'b1;
               maj_ff   <= maj_ff + 1'b1;
               if (rem_carry) begin
                  rem_ff <= rem_sum - {1'b0, maj_span_ff};
                  min_ff <= neg_ff ? min_ff - 1'b1 : min_ff + 1'b1;
               end else begin
                  rem_ff <= rem_sum;
               end
               state_ff <= S_PLOT;
            end
         end
      end
   end

   // The store is written only while a command or the reset sweep runs.
   assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == S_CLEAR || state_ff == S_MODIFY))
      else $error("store written outside clear or modify");

   // A modify step always follows a plot step that issued the read.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MODIFY) |-> $past(state_ff == S_PLOT))
      else $error("modify without preceding read");

   // The walker remainder stays below a nonzero major span.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PLOT && maj_span_ff != 8'd0) |-> (rem_ff < {1'b0, maj_span_ff}))
      else $error("line remainder out of range");

   // The pixel result is zero for any command other than get.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && cmd_ff != CMD_GET) |-> (pv_ff == 1'b0))
      else $error("pixel value set for non-get command");

endmodule

@@ tb/sv/page_framebuffer_draw_engine_tb.sv @@
// Self-checking testbench for the page framebuffer draw engine.
`timescale 1ns / 100ps

module page_framebuffer_draw_engine_tb;
   import pfde_pkg::*;

   localparam int WIDTH  = 128;
   localparam int HEIGHT = 64;

   typedef struct {
      command_type cmd;
      logic [7:0]  xa, ya, xb, yb;
      logic        ink;
      logic [9:0]  addr;
   } draw_request_type;

   typedef struct {
      logic       pixel;
      logic [7:0] byte_val;
   } readback_type;

   // Frame store predictor plus the queue of readbacks it predicts.
   class frame_scoreboard;
      logic [7:0]   store [STORE_DEPTH];
      readback_type pending [$];
      int           mismatches;
      int           checked;

      function new();
         foreach (store[i]) store[i] = '0;
         mismatches = 0;
         checked = 0;
      endfunction

      function void plot(int x, int y, logic ink);
         int i;
         if (x < 0 || y < 0 || x >= WIDTH || y >= HEIGHT) return;
         i = (y / 8) * WIDTH + x;
         if (i >= STORE_DEPTH) return;
         store[i][y % 8] = ink;
      endfunction

      function logic peek(int x, int y);
         int i;
         if (x >= WIDTH || y >= HEIGHT) return 1'b0;
         i = (y / 8) * WIDTH + x;
         if (i >= STORE_DEPTH) return 1'b0;
         return store[i][y % 8];
      endfunction

      // Major-axis stepping; x is major on equal spans, minor follows true direction.
      function void line(int x0, int y0, int x1, int y1, logic ink);
         int dx, dy, sx, sy, ex, ey, off;
         dx = (x1 >= x0) ? x1 - x0 : x0 - x1;
         dy = (y1 >= y0) ? y1 - y0 : y0 - y1;
         if (dx >= dy) begin
            if (x0 <= x1) begin sx = x0; sy = y0; ey = y1; end
            else begin sx = x1; sy = y1; ey = y0; end
            for (int t = 0; t <= dx; t++) begin
               off = (dx == 0) ? 0 : (t * dy) / dx;
               plot(sx + t, (ey >= sy) ? sy + off : sy - off, ink);
            end
         end else begin
            if (y0 <= y1) begin sy = y0; sx = x0; ex = x1; end
            else begin sy = y1; sx = x1; ex = x0; end
            for (int t = 0; t <= dy; t++) begin
               off = (t * dx) / dy;
               plot((ex >= sx) ? sx + off : sx - off, sy + t, ink);
            end
         end
      endfunction

      function void note_request(draw_request_type r);
         readback_type rb;
         int lox, hix, loy, hiy;
         rb.pixel = 1'b0;
         rb.byte_val = '0;
         case (r.cmd)
            CMD_CLEAR: foreach (store[i]) store[i] = '0;
            CMD_SET: plot(r.xa, r.ya, r.ink);
            CMD_GET: rb.pixel = peek(r.xa, r.ya);
            CMD_LINE: line(r.xa, r.ya, r.xb, r.yb, r.ink);
            CMD_OUTLINE: begin
               line(r.xa, r.ya, r.xa, r.yb, r.ink);
               line(r.xa, r.ya, r.xb, r.ya, r.ink);
               line(r.xa, r.yb, r.xb, r.yb, r.ink);
               line(r.xb, r.ya, r.xb, r.yb, r.ink);
            end
            CMD_FILL: begin
               lox = (r.xa <= r.xb) ? r.xa : r.xb;
               hix = (r.xa <= r.xb) ? r.xb : r.xa;
               loy = (r.ya <= r.yb) ? r.ya : r.yb;
               hiy = (r.ya <= r.yb) ? r.yb : r.ya;
               for (int y = loy; y <= hiy; y++)
                  for (int x = lox; x <= hix; x++) plot(x, y, r.ink);
            end
            CMD_BYTE: if (r.addr < STORE_DEPTH) rb.byte_val = store[r.addr];
            default: ;
         endcase
         pending.push_back(rb);
      endfunction

      function void check_readback(logic pixel, logic [7:0] byte_val);
         readback_type e;
         checked++;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response pix=%0b byte=%02h",
               pixel, byte_val);
            return;
         end
         e = pending.pop_front();
         if (pixel !== e.pixel || byte_val !== e.byte_val) begin
            mismatches++;
            if (mismatches <= 10)
               $display("response %0d mismatch: pix exp %0b got %0b, byte exp %02h got %02h",
                  checked, e.pixel, pixel, e.byte_val, byte_val);
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   command_type req_command = CMD_NONE;
   logic [7:0]  req_x_start = '0, req_y_start = '0, req_x_end = '0, req_y_end = '0;
   logic        req_ink = 1'b0;
   logic [9:0]  req_byte_address = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_pixel_value;
   logic [7:0]  rsp_byte_value;

   frame_scoreboard sb = new();
   bit  stall_hold = 1'b0;     // force a long receiver hold-off
   bit  stall_free = 1'b0;     // receiver never stalls
   int  sent = 0;
   int  cmd_count [8];

   always #1 clock = ~clock;

   page_framebuffer_draw_engine #(.WIDTH(WIDTH), .HEIGHT(HEIGHT)) uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_command(req_command),
      .req_x_start(req_x_start), .req_y_start(req_y_start), .req_x_end(req_x_end),
      .req_y_end(req_y_end), .req_ink(req_ink), .req_byte_address(req_byte_address),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_pixel_value(rsp_pixel_value), .rsp_byte_value(rsp_byte_value));

   // Check every accepted response at the rising edge.
   always @(posedge clock)
      if (!reset && rsp_valid && !rsp_stall) sb.check_readback(rsp_pixel_value, rsp_byte_value);

   // Receiver stall pattern: free-run phases, dense stalls, and forced hold-offs.
   always @(negedge clock) begin
      if (stall_hold) rsp_stall <= 1'b1;
      else if (stall_free) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(0, 3) == 0);
   end

   // Offer one request and hold it until the block takes it.
   task automatic send(draw_request_type r);
      req_valid <= 1'b1;
      req_command <= r.cmd;
      req_x_start <= r.xa;
      req_y_start <= r.ya;
      req_x_end <= r.xb;
      req_y_end <= r.yb;
      req_ink <= r.ink;
      req_byte_address <= r.addr;
      do @(posedge clock); while (req_stall);
      sb.note_request(r);
      sent++;
      cmd_count[r.cmd]++;
      @(negedge clock);
   endtask

   task automatic idle(int n);
      req_valid <= 1'b0;
      req_command <= command_type'($urandom_range(0, 7));
      req_x_start <= 8'($urandom);
      req_byte_address <= 10'($urandom);
      repeat (n) @(negedge clock);
   endtask

   function automatic draw_request_type make(command_type c, int xa, int ya, int xb, int yb,
                                             bit ink, int addr);
      draw_request_type r;
      r.cmd = c; r.xa = 8'(xa); r.ya = 8'(ya); r.xb = 8'(xb); r.yb = 8'(yb);
      r.ink = ink; r.addr = 10'(addr);
      return r;
   endfunction

   // Random request: small shapes near the visible area dominate, so most draw real pixels.
   function automatic draw_request_type random_request();
      draw_request_type r;
      int sel, span;
      sel = $urandom_range(0, 99);
      if (sel < 3) r.cmd = CMD_CLEAR;
      else if (sel < 23) r.cmd = CMD_SET;
      else if (sel < 43) r.cmd = CMD_GET;
      else if (sel < 58) r.cmd = CMD_LINE;
      else if (sel < 65) r.cmd = CMD_OUTLINE;
      else if (sel < 70) r.cmd = CMD_FILL;
      else if (sel < 97) r.cmd = CMD_BYTE;
      else r.cmd = CMD_NONE;
      span = (r.cmd == CMD_FILL) ? 6 : 24;
      if ($urandom_range(0, 9) == 0) begin
         r.xa = 8'($urandom); r.ya = 8'($urandom);
      end else begin
         r.xa = 8'($urandom_range(0, WIDTH + 3));
         r.ya = 8'($urandom_range(0, HEIGHT + 3));
      end
      if ($urandom_range(0, 19) == 0 && r.cmd != CMD_FILL) begin
         r.xb = 8'($urandom); r.yb = 8'($urandom);
      end else begin
         r.xb = 8'(int'(r.xa) + int'($urandom_range(0, 2 * span)) - span);
         r.yb = 8'(int'(r.ya) + int'($urandom_range(0, 2 * span)) - span);
         if (r.cmd == CMD_FILL) begin
            // keep fills compact even when the offset wraps around
            if (r.xb > r.xa + span && r.xa + span < 256) r.xb = r.xa;
            if (r.yb > r.ya + span && r.ya + span < 256) r.yb = r.ya;
         end
      end
      r.ink = ($urandom_range(0, 3) != 0);
      r.addr = ($urandom_range(0, 9) == 0) ? 10'($urandom) : 10'($urandom_range(0, 1023));
      return r;
   endfunction

   task automatic wait_drained();
      while (sb.pending.size() != 0) @(negedge clock);
   endtask

   initial begin
      draw_request_type r;
      int burst;
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // Directed: corners, clipping, zero-length and reversed shapes, every command.
      send(make(CMD_SET, 0, 0, 0, 0, 1, 0));
      send(make(CMD_SET, WIDTH - 1, HEIGHT - 1, 0, 0, 1, 0));
      send(make(CMD_SET, 255, 255, 0, 0, 1, 0));
      send(make(CMD_GET, 0, 0, 0, 0, 0, 0));
      send(make(CMD_GET, WIDTH - 1, HEIGHT - 1, 0, 0, 0, 0));
      send(make(CMD_GET, 255, 255, 0, 0, 0, 0));
      send(make(CMD_BYTE, 0, 0, 0, 0, 0, 0));
      send(make(CMD_BYTE, 0, 0, 0, 0, 0, 1023));
      send(make(CMD_LINE, 10, 10, 10, 10, 1, 0));
      send(make(CMD_LINE, 40, 5, 20, 30, 1, 0));
      send(make(CMD_LINE, 20, 30, 40, 5, 1, 0));
      send(make(CMD_LINE, 0, 0, 255, 255, 1, 0));
      send(make(CMD_LINE, 5, 50, 50, 5, 1, 0));
      send(make(CMD_OUTLINE, 60, 40, 50, 20, 1, 0));
      send(make(CMD_FILL, 100, 62, 96, 55, 1, 0));
      send(make(CMD_FILL, 99, 60, 97, 57, 0, 0));
      send(make(CMD_BYTE, 0, 0, 0, 0, 0, 7 * WIDTH + 98));
      send(make(CMD_NONE, 255, 255, 255, 255, 1, 1023));
      send(make(CMD_BYTE, 0, 0, 0, 0, 0, WIDTH + 30));
      send(make(CMD_CLEAR, 0, 0, 0, 0, 0, 0));
      send(make(CMD_BYTE, 0, 0, 0, 0, 0, WIDTH + 30));
      send(make(CMD_GET, 10, 10, 0, 0, 0, 0));

      // Long receiver hold-off while requests keep coming, so the input backs up.
      stall_hold = 1'b1;
      fork
         begin repeat (400) @(negedge clock); stall_hold = 1'b0; end
         for (int i = 0; i < 8; i++) send(make(CMD_SET, i, i, 0, 0, 1, 0));
      join
      // Drop the request, pause until every response is back, then run with an open receiver.
      req_valid <= 1'b0;
      wait_drained();
      stall_free = 1'b1;

      while (sent < 850) begin
         burst = $urandom_range(1, 20);
         repeat (burst) send(random_request());
         if ($urandom_range(0, 1)) idle($urandom_range(1, 6));
         if (sent > 300) stall_free = 1'b0;
      end
      req_valid <= 1'b0;
      wait_drained();
      repeat (20) @(negedge clock);

      $display("Ran %0d requests: clear %0d set %0d get %0d line %0d outline %0d fill %0d",
         sent, cmd_count[0], cmd_count[1], cmd_count[2], cmd_count[3], cmd_count[4],
         cmd_count[5]);
      $display("  byte reads %0d, unused code %0d, %0d responses checked, %0d mismatches",
         cmd_count[6], cmd_count[7], sb.checked, sb.mismatches);
      if (sb.mismatches == 0 && sb.pending.size() == 0)
         $display("page_framebuffer_draw_engine_tb: PASS");
      else
         $display("page_framebuffer_draw_engine_tb: FAIL");
      $finish;
   end

   initial begin
      #10000000;
      $display("page_framebuffer_draw_engine_tb: FAIL");
      $finish;
   end

endmodule

@@ files.f @@
rtl/core/pfde_pkg.sv
rtl/core/page_framebuffer_draw_engine.sv
tb/sv/page_framebuffer_draw_engine_tb.sv
